FILE: sv/rc_pkg.sv
// ----------------------------------------------------------------------------
// rc_pkg
// Shared types and constants of the radix converter: character codes, error
// codes, configuration register indexes and the job control word.
// ----------------------------------------------------------------------------
package rc_pkg;

	// Character codes.
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_NUL     = 8'h00;

	// Error codes of a result.
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_INVALID  = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 2'd1;

	// Base registers and their limits.
	localparam int unsigned BASE_W = 5;
	localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;
	localparam logic [BASE_W-1:0] SOURCE_BASE_RESET = 5'd10;
	localparam logic [BASE_W-1:0] TARGET_BASE_RESET = 5'd2;

	// Digit scratch store.
	localparam int unsigned DIGIT_DEPTH = 64;
	localparam int unsigned DIGIT_AW    = 6;
	localparam int unsigned DIGIT_W     = 4;

	// Control part of one finished number handed from front to back.
	typedef struct packed {
		logic [1:0] err;
		logic       neg;
	} job_ctl_t;

	localparam int unsigned JOB_CTL_W = 3;

endpackage

FILE: sv/rc_ram.sv
// ----------------------------------------------------------------------------
// rc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rc_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/rc_front.sv
// ----------------------------------------------------------------------------
// rc_front
// Character front end: strips the sign and prefix, decodes digits and folds
// them into the running value with an overflow check. On the last character
// it hands the finished number to the back end through the job queue.
// ----------------------------------------------------------------------------
module rc_front
	import rc_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 63
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              char_code,
	input  logic                    last_char,
	input  logic [BASE_W-1:0]       source_base,
	output logic                    job_push,
	output job_ctl_t                job_ctl,
	output logic [VALUE_BITS-1:0]   job_value,
	input  logic                    job_full
);

	localparam int unsigned PW = VALUE_BITS + BASE_W;

	typedef enum logic [3:0] {
		PH_FIRST       = 4'b0001,
		PH_AFTER_MINUS = 4'b0010,
		PH_AFTER_ZERO  = 4'b0100,
		PH_DIGITS      = 4'b1000
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [VALUE_BITS-1:0] acc_q, acc_d;
	logic                  neg_q, neg_d;
	logic [1:0]            err_q, err_d;

	logic                  is_digit;
	logic [3:0]            digit;
	logic [PW-1:0]         prod;
	logic                  ovf;
	logic                  accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = !job_full;

	always_comb begin
		is_digit = 1'b1;
		digit    = 4'd0;
		if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
			digit = 4'(char_code - CH_ZERO);
		end else if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_F) begin
			digit = 4'(char_code - CH_UPPER_A + 8'd10);
		end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_F) begin
			digit = 4'(char_code - CH_LOWER_A + 8'd10);
		end else begin
			is_digit = 1'b0;
		end
	end

	// The new value overflows exactly when acc * base + digit exceeds the
	// largest value that fits in VALUE_BITS bits.
	assign prod = PW'(acc_q) * PW'(source_base) + PW'(digit);
	assign ovf  = |prod[PW-1:VALUE_BITS];

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		err_d   = err_q;
		if (phase_q == PH_FIRST && char_code == CH_MINUS) begin
			neg_d   = 1'b1;
			phase_d = PH_AFTER_MINUS;
		end else if ((phase_q == PH_FIRST || phase_q == PH_AFTER_MINUS) &&
			char_code == CH_ZERO) begin
			phase_d = PH_AFTER_ZERO;
		end else if (phase_q == PH_AFTER_ZERO &&
			(char_code == CH_LOWER_X || char_code == CH_UPPER_X)) begin
			phase_d = PH_DIGITS;
		end else begin
			phase_d = PH_DIGITS;
			if (!is_digit) begin
				if (err_q == ERR_NONE) begin
					err_d = ERR_INVALID;
				end
			end else if (err_q == ERR_NONE) begin
				if (ovf) begin
					err_d = ERR_OVERFLOW;
				end else begin
					acc_d = prod[VALUE_BITS-1:0];
				end
			end
		end
	end

	assign job_push      = accept && last_char;
	assign job_ctl.err   = err_d;
	assign job_ctl.neg   = neg_d;
	assign job_value     = acc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			err_q   <= ERR_NONE;
		end else if (accept) begin
			if (last_char) begin
				phase_q <= PH_FIRST;
				acc_q   <= '0;
				neg_q   <= 1'b0;
				err_q   <= ERR_NONE;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				err_q   <= err_d;
			end
		end
	end

endmodule

FILE: sv/rc_fifo.sv
// ----------------------------------------------------------------------------
// rc_fifo
// Short job queue between the character front end and the conversion back
// end, so that each side can stall without holding up the other.
// ----------------------------------------------------------------------------
module rc_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNTW = AW + 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNTW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/rc_back.sv
// ----------------------------------------------------------------------------
// rc_back
// Conversion back end: divides the number by the target base four quotient
// bits per cycle, stores the remainders, then plays them back most
// significant first through the output register.
// ----------------------------------------------------------------------------
module rc_back
	import rc_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 63
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [BASE_W-1:0]     target_base,
	input  logic                  job_empty,
	output logic                  job_pop,
	input  job_ctl_t              job_ctl,
	input  logic [VALUE_BITS-1:0] job_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_char,
	output logic                  last_out,
	output logic [1:0]            error_code
);

	// The dividend register is padded to whole groups of four bits.
	localparam int unsigned DW    = ((VALUE_BITS + 3) / 4) * 4;
	localparam int unsigned STEPS = DW / 4;
	localparam int unsigned CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_DIV  = 6'b000010,
		B_SIGN = 6'b000100,
		B_READ = 6'b001000,
		B_EMIT = 6'b010000,
		B_ERR  = 6'b100000
	} bstate_t;

	bstate_t               state_q;
	logic [DW-1:0]         div_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [CW-1:0]         cnt_q;
	logic [DIGIT_AW-1:0]   n_q;
	logic                  neg_q;
	logic [1:0]            err_q;

	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic                  last_out_q;
	logic [1:0]            error_code_q;

	logic [DW-1:0]         div_nxt;
	logic [DIGIT_W-1:0]    rem_nxt;
	logic                  last_step;
	logic                  out_free;
	logic                  out_load;
	logic [7:0]            load_char;
	logic                  load_last;
	logic [1:0]            load_err;
	logic                  ram_we;
	logic                  ram_re;
	logic [DIGIT_AW-1:0]   ram_raddr;
	logic [DIGIT_W-1:0]    ram_rdata;

	function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
		if (d < 4'd10) begin
			return CH_ZERO + {4'd0, d};
		end
		return CH_UPPER_A + {4'd0, d} - 8'd10;
	endfunction

	// Four restoring division steps; the remainder stays below the base, so
	// it always fits in four bits.
	always_comb begin
		logic [4:0]         r;
		logic [DIGIT_W-1:0] rr;
		logic [3:0]         qb;
		rr = rem_q;
		qb = 4'd0;
		for (int i = 0; i < 4; i++) begin
			r = {rr, div_q[DW-1-i]};
			if (r >= target_base) begin
				r         = r - target_base;
				qb[3-i]   = 1'b1;
			end
			rr = r[DIGIT_W-1:0];
		end
		rem_nxt = rr;
		div_nxt = {div_q[DW-5:0], qb};
	end

	assign last_step = (cnt_q == CW'(STEPS - 1));
	assign out_free  = !out_valid_q || out_ready;
	assign job_pop   = (state_q == B_IDLE) && !job_empty;
	assign ram_raddr = n_q - 1'b1;

	always_comb begin
		out_load  = 1'b0;
		load_char = CH_NUL;
		load_last = 1'b0;
		load_err  = ERR_NONE;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		case (state_q)
			B_DIV: begin
				ram_we = last_step;
			end
			B_SIGN: begin
				if (neg_q && out_free) begin
					out_load  = 1'b1;
					load_char = CH_MINUS;
				end
			end
			B_READ: begin
				ram_re = 1'b1;
			end
			B_EMIT: begin
				if (out_free) begin
					out_load  = 1'b1;
					load_char = digit_char(ram_rdata);
					load_last = (n_q == '0);
				end
			end
			B_ERR: begin
				if (out_free) begin
					out_load  = 1'b1;
					load_last = 1'b1;
					load_err  = err_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
			neg_q   <= 1'b0;
			err_q   <= ERR_NONE;
			rem_q   <= '0;
			div_q   <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						div_q   <= DW'(job_value);
						neg_q   <= job_ctl.neg;
						err_q   <= job_ctl.err;
						rem_q   <= '0;
						cnt_q   <= '0;
						n_q     <= '0;
						state_q <= (job_ctl.err != ERR_NONE) ? B_ERR : B_DIV;
					end
				end
				B_DIV: begin
					div_q <= div_nxt;
					if (last_step) begin
						rem_q <= '0;
						cnt_q <= '0;
						n_q   <= n_q + 1'b1;
						if (div_nxt == '0) begin
							state_q <= B_SIGN;
						end
					end else begin
						rem_q <= rem_nxt;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				B_SIGN: begin
					if (!neg_q || out_free) begin
						state_q <= B_READ;
					end
				end
				B_READ: begin
					n_q     <= n_q - 1'b1;
					state_q <= B_EMIT;
				end
				B_EMIT: begin
					if (out_free) begin
						state_q <= (n_q == '0) ? B_IDLE : B_READ;
					end
				end
				B_ERR: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_char_q   <= load_char;
			last_out_q   <= load_last;
			error_code_q <= load_err;
		end
	end

	rc_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (DIGIT_DEPTH)
	) u_digit_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (n_q),
		.wdata (rem_nxt),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign last_out   = last_out_q;
	assign error_code = error_code_q;

endmodule

FILE: sv/radix_converter.sv
// ----------------------------------------------------------------------------
// radix_converter
// Converts one number, given as ASCII text in the source base, into ASCII
// text in the target base, with sign handling and error reporting.
// ----------------------------------------------------------------------------
// Usage: characters of a number arrive on the input channel (char_code,
// last_char), one transaction per character. A leading '-', then a '0', then
// an 'x' or 'X' are stripped; digits are folded in at one character a cycle
// while the job queue has room. The last character closes the number and
// queues it for conversion; the front end then takes the next number at once
// while the back end works. Results leave on the output channel: an optional
// '-', then the digits most significant first, last_out on the final one. A
// bad character or overflow gives one result with error_code set instead.
// Conversion runs one divide by the target base per output digit, four
// quotient bits per cycle with VALUE_BITS padded to groups of four; the sign
// state follows, then each digit is read back from the digit RAM and emitted.
// A stalled receiver holds the output register; the job queue (two numbers)
// keeps the front end running until it fills. Reset restores bases 10 and 2
// and drops any number in progress. Configuration is taken any cycle.
// ----------------------------------------------------------------------------
module radix_converter
	import rc_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 63
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BASE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           char_code,
	input  logic                 last_char,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_char,
	output logic                 last_out,
	output logic [1:0]           error_code
);

	localparam int unsigned JW = VALUE_BITS + JOB_CTL_W;

	logic [BASE_W-1:0]     src_base_q;
	logic [BASE_W-1:0]     tgt_base_q;
	logic [BASE_W-1:0]     cfg_clamped;

	logic                  job_push;
	job_ctl_t              push_ctl;
	logic [VALUE_BITS-1:0] push_value;
	logic                  job_full;
	logic                  job_pop;
	logic                  job_empty;
	logic [JW-1:0]         pop_data;
	job_ctl_t              pop_ctl;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (cfg_data < BASE_MIN) begin
			cfg_clamped = BASE_MIN;
		end else if (cfg_data > BASE_MAX) begin
			cfg_clamped = BASE_MAX;
		end else begin
			cfg_clamped = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_base_q <= SOURCE_BASE_RESET;
			tgt_base_q <= TARGET_BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SOURCE_BASE) begin
				src_base_q <= cfg_clamped;
			end else if (cfg_index == REG_TARGET_BASE) begin
				tgt_base_q <= cfg_clamped;
			end
		end
	end

	rc_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.last_char   (last_char),
		.source_base (src_base_q),
		.job_push    (job_push),
		.job_ctl     (push_ctl),
		.job_value   (push_value),
		.job_full    (job_full)
	);

	rc_fifo #(
		.WIDTH (JW),
		.DEPTH (2)
	) u_job_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data ({push_ctl, push_value}),
		.full      (job_full),
		.pop       (job_pop),
		.pop_data  (pop_data),
		.empty     (job_empty)
	);

	assign pop_ctl = job_ctl_t'(pop_data[JW-1:VALUE_BITS]);

	rc_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.target_base (tgt_base_q),
		.job_empty   (job_empty),
		.job_pop     (job_pop),
		.job_ctl     (pop_ctl),
		.job_value   (pop_data[VALUE_BITS-1:0]),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_out    (last_out),
		.error_code  (error_code)
	);

`ifndef ASSERT_OFF
	// A finished number is never offered to a full job queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into full queue");

	// An error result is a single, final result with no character.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code != ERR_NONE) |-> (last_out && out_char == CH_NUL))
		else $error("malformed error result");

	// A sign is always followed by at least one digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_char == CH_MINUS) |-> !last_out)
		else $error("sign marked as final result");
`endif

endmodule
